// ===== rtl/rdwr_pkg.sv =====
// Shared types, constants and codes for the random draw without replacement block.
package rdwr_pkg;

    // Pool geometry
    localparam int POOL_DEPTH = 1024;
    localparam int NUM_W      = 11;
    localparam int ADDR_W     = $clog2(POOL_DEPTH);
    localparam int RND_W      = 32;
    localparam int STEP_W     = $clog2(RND_W);

    // Pool depth as a count value
    localparam logic [NUM_W-1:0] DEPTH_CNT = NUM_W'(POOL_DEPTH);

    // Reset value of the pool size register
    localparam logic [NUM_W-1:0] POOL_SIZE_RST = NUM_W'(1024);

    // Command codes
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_DRAW    = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DRAWN   = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_RESTART = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_DIV,
        S_RD_SEL,
        S_RD_LAST,
        S_WRITE
    } t_state;

endpackage

// ===== rtl/rdwr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rdwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rdwr_divider.sv =====
// Restoring divider, one quotient bit a cycle, that returns the remainder only.
module rdwr_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rdwr_pkg::RND_W-1:0]    i_dividend,
    input  logic [rdwr_pkg::NUM_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [rdwr_pkg::NUM_W-1:0]    o_remainder
);

    logic                          r_busy;
    logic                          r_done;
    logic [rdwr_pkg::STEP_W-1:0]   r_step;
    logic [rdwr_pkg::RND_W-1:0]    r_dvd;
    logic [rdwr_pkg::NUM_W-1:0]    r_dvs;
    logic [rdwr_pkg::NUM_W-1:0]    r_rem;
    logic [rdwr_pkg::NUM_W:0]      trial;
    logic [rdwr_pkg::NUM_W-1:0]    n_rem;

    // Shift in the next dividend bit and subtract when it fits
    always_comb begin
        trial = {r_rem, r_dvd[rdwr_pkg::RND_W-1]};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = rdwr_pkg::NUM_W'(trial - {1'b0, r_dvs});
        end else begin
            n_rem = trial[rdwr_pkg::NUM_W-1:0];
        end
    end

    // Control: run one step per cycle, pulse done after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == rdwr_pkg::STEP_W'(rdwr_pkg::RND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[rdwr_pkg::RND_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

// ===== rtl/random_draw_without_replacement.sv =====
// Top level: pool sequencer around the remainder divider and the pool RAM.
//
// Commands are taken while o_busy is low. A draw first computes the bit-serial
// remainder of the 32-bit random word by the remaining count, then makes 3
// pool RAM accesses on its one read and one write port (read the chosen slot,
// read the last slot, move the last entry in), then loads the result register.
// A restart writes min(pool_size, 1024) pool entries, one entry a cycle; a draw
// on an empty pool and a restart to size zero answer in the cycle after they
// are accepted. Each result appears for one cycle with o_result_valid and
// must be taken then; it cannot be held off.
// The pool size register is written through the cfg channel, which is
// always ready, and must only be written while the block is idle.
module random_draw_without_replacement (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_cmd,
    input  logic [rdwr_pkg::RND_W-1:0]    i_random_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rdwr_pkg::NUM_W-1:0]    i_cfg_data,
    output logic                          o_result_valid,
    output logic [rdwr_pkg::NUM_W-1:0]    o_drawn_number,
    output logic [1:0]                    o_status,
    output logic [rdwr_pkg::NUM_W-1:0]    o_numbers_left
);

    rdwr_pkg::t_state              r_state;
    rdwr_pkg::t_state              n_state;
    logic [rdwr_pkg::NUM_W-1:0]    r_pool_size;
    logic [rdwr_pkg::NUM_W-1:0]    r_count;
    logic [rdwr_pkg::NUM_W-1:0]    n_count;
    logic [rdwr_pkg::NUM_W-1:0]    r_fill;
    logic [rdwr_pkg::NUM_W-1:0]    r_fill_end;
    logic [rdwr_pkg::NUM_W-1:0]    r_drawn;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [rdwr_pkg::NUM_W-1:0]    r_out_drawn;
    logic [rdwr_pkg::NUM_W-1:0]    n_out_drawn;
    rdwr_pkg::t_status             r_out_status;
    rdwr_pkg::t_status             n_out_status;
    logic [rdwr_pkg::NUM_W-1:0]    r_out_left;
    logic [rdwr_pkg::NUM_W-1:0]    n_out_left;

    logic                          accept;
    logic                          pool_empty;
    logic [rdwr_pkg::NUM_W-1:0]    fill_size;
    logic [rdwr_pkg::NUM_W-1:0]    fill_next;
    logic [rdwr_pkg::NUM_W-1:0]    last;
    logic                          div_start;
    logic                          div_done;
    logic [rdwr_pkg::NUM_W-1:0]    div_rem;
    logic                          ram_we;
    logic [rdwr_pkg::ADDR_W-1:0]   ram_waddr;
    logic [rdwr_pkg::NUM_W-1:0]    ram_wdata;
    logic [rdwr_pkg::ADDR_W-1:0]   ram_raddr;
    logic [rdwr_pkg::NUM_W-1:0]    ram_rdata;

    assign accept      = i_start && (r_state == rdwr_pkg::S_IDLE);
    assign pool_empty  = (r_count == '0) || (r_count > rdwr_pkg::DEPTH_CNT);
    assign fill_size   = (r_pool_size > rdwr_pkg::DEPTH_CNT) ? rdwr_pkg::DEPTH_CNT
                                                             : r_pool_size;
    assign fill_next   = r_fill + 1'b1;
    assign last        = r_count - 1'b1;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rdwr_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_cmd == rdwr_pkg::CMD_RESTART) begin
                        if (fill_size != '0) begin
                            n_state = rdwr_pkg::S_FILL;
                        end
                    end else if (!pool_empty) begin
                        n_state = rdwr_pkg::S_DIV;
                    end
                end
            end
            rdwr_pkg::S_FILL: begin
                if (fill_next == r_fill_end) begin
                    n_state = rdwr_pkg::S_IDLE;
                end
            end
            rdwr_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = rdwr_pkg::S_RD_SEL;
                end
            end
            rdwr_pkg::S_RD_SEL:  n_state = rdwr_pkg::S_RD_LAST;
            rdwr_pkg::S_RD_LAST: n_state = rdwr_pkg::S_WRITE;
            rdwr_pkg::S_WRITE:   n_state = rdwr_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer: RAM, divider and result controls
    always_comb begin
        n_count      = r_count;
        n_out_valid  = 1'b0;
        n_out_drawn  = '0;
        n_out_status = rdwr_pkg::ST_DRAWN;
        n_out_left   = r_count;
        div_start    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_fill[rdwr_pkg::ADDR_W-1:0];
        ram_wdata    = fill_next;
        ram_raddr    = div_rem[rdwr_pkg::ADDR_W-1:0];
        unique case (r_state)
            rdwr_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_cmd == rdwr_pkg::CMD_RESTART) begin
                        // Empty restart answers without filling the pool
                        if (fill_size == '0) begin
                            n_count      = '0;
                            n_out_valid  = 1'b1;
                            n_out_status = rdwr_pkg::ST_RESTART;
                            n_out_left   = '0;
                        end
                    end else if (pool_empty) begin
                        n_out_valid  = 1'b1;
                        n_out_status = rdwr_pkg::ST_EMPTY;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            rdwr_pkg::S_FILL: begin
                ram_we = 1'b1;
                if (fill_next == r_fill_end) begin
                    n_count      = r_fill_end;
                    n_out_valid  = 1'b1;
                    n_out_status = rdwr_pkg::ST_RESTART;
                    n_out_left   = r_fill_end;
                end
            end
            rdwr_pkg::S_DIV: begin
            end
            rdwr_pkg::S_RD_SEL: begin
                ram_raddr = div_rem[rdwr_pkg::ADDR_W-1:0];
            end
            rdwr_pkg::S_RD_LAST: begin
                ram_raddr = last[rdwr_pkg::ADDR_W-1:0];
            end
            rdwr_pkg::S_WRITE: begin
                // Move the last entry into the drawn slot and shrink the pool
                ram_we       = 1'b1;
                ram_waddr    = div_rem[rdwr_pkg::ADDR_W-1:0];
                ram_wdata    = ram_rdata;
                n_count      = last;
                n_out_valid  = 1'b1;
                n_out_drawn  = r_drawn;
                n_out_status = rdwr_pkg::ST_DRAWN;
                n_out_left   = last;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rdwr_pkg::S_IDLE;
            r_count     <= '0;
            r_pool_size <= rdwr_pkg::POOL_SIZE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_pool_size <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fill     <= '0;
            r_fill_end <= fill_size;
        end else if (r_state == rdwr_pkg::S_FILL) begin
            r_fill <= fill_next;
        end
        if (r_state == rdwr_pkg::S_RD_LAST) begin
            r_drawn <= ram_rdata;
        end
        r_out_drawn  <= n_out_drawn;
        r_out_status <= n_out_status;
        r_out_left   <= n_out_left;
    end

    rdwr_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (i_random_value),
        .i_divisor   (r_count),
        .o_done      (div_done),
        .o_remainder (div_rem)
    );

    rdwr_ram #(
        .WIDTH (rdwr_pkg::NUM_W),
        .DEPTH (rdwr_pkg::POOL_DEPTH)
    ) u_pool (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_busy         = (r_state != rdwr_pkg::S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_out_valid;
    assign o_drawn_number = r_out_drawn;
    assign o_status       = r_out_status;
    assign o_numbers_left = r_out_left;

endmodule
